// ===== rtl/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

   localparam logic [2:0] KIND_NORM  = 3'd0;
   localparam logic [2:0] KIND_ADD   = 3'd1;
   localparam logic [2:0] KIND_SUB   = 3'd2;
   localparam logic [2:0] KIND_MUL   = 3'd3;
   localparam logic [2:0] KIND_DIV   = 3'd4;
   localparam logic [2:0] KIND_NEG   = 3'd5;
   localparam logic [2:0] KIND_EQ    = 3'd6;
   localparam logic [2:0] KIND_SPARE = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [3:0] {
      OP_PRODUCT = 4'b0001,
      OP_COMBINE = 4'b0010,
      OP_GCD     = 4'b0100,
      OP_DIVIDE  = 4'b1000
   } op_type;

   typedef struct packed {
      logic   load;
      logic   step;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic done;
   } sts_type;

endpackage

// ===== rtl/rau_datapath.sv =====
// Datapath: operand decode, cross products, binary GCD and two restoring dividers.
module rau_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic [2:0]           req_kind,
   input  logic [31:0]          req_a_num,
   input  logic [31:0]          req_a_den,
   input  logic [31:0]          req_b_num,
   input  logic [31:0]          req_b_den,
   input  rau_pkg::cmd_type     cmd,
   output rau_pkg::sts_type     sts,
   output logic [31:0]          res_num,
   output logic [30:0]          res_den,
   output logic                 res_eq,
   output logic [1:0]           res_status
);
   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W;
   localparam int PW1 = PW + 1;
   localparam int CW = $clog2(PW1 + 1);

   logic [W-1:0]   an_m, ad_m, bn_m, bd_m;
   logic           an_s, ad_s, bn_s, bd_s;

   // decode
   function automatic logic [W:0] dec(input logic [31:0] raw);
      logic [W-1:0] v;
      v = raw[W-1:0];
      dec = {v[W-1], v[W-1] ? (~v + 1'b1) : v};
   endfunction

   logic [W:0] d0, d1, d2, d3;
   assign d0 = dec(req_a_num);
   assign d1 = dec(req_a_den);
   assign d2 = dec(req_b_num);
   assign d3 = dec(req_b_den);

   logic [2:0]     kind_ff, kind_in;
   logic [W-1:0]   am_ff, adm_ff, bm_ff, bdm_ff;
   logic           as_ff, ads_ff, bs_ff, bds_ff;
   logic [PW-1:0]  p0_ff, p1_ff, p2_ff;
   logic           s0_ff, s1_ff, s2_ff;
   logic [PW1-1:0] nm_ff, nm_in, dm_ff, dm_in;
   logic           neg_ff, neg_in;
   logic [PW1-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [CW-1:0]  sh_ff, sh_in;
   logic [PW1-1:0] g_ff;
   logic [PW1-1:0] qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           qk_ff, qk_in, done_ff, done_in;
   logic [31:0]    on_ff, on_in;
   logic [30:0]    od_ff, od_in;
   logic           oe_ff, oe_in;
   logic [1:0]     os_ff, os_in;

   assign an_m = am_ff;  assign ad_m = adm_ff; assign bn_m = bm_ff; assign bd_m = bdm_ff;
   assign an_s = as_ff;  assign ad_s = ads_ff; assign bn_s = bs_ff; assign bd_s = bds_ff;

   logic uses_b;
   assign uses_b = (req_kind >= rau_pkg::KIND_ADD && req_kind <= rau_pkg::KIND_DIV)
                   || req_kind == rau_pkg::KIND_EQ;

   // combine
   logic [PW1-1:0] ca, cb, csum;
   logic           cneg, sub_neg;
   assign ca = {1'b0, p0_ff};
   assign cb = {1'b0, p1_ff};
   assign sub_neg = s1_ff ^ (kind_ff == rau_pkg::KIND_SUB || kind_ff == rau_pkg::KIND_EQ);

   // gcd step
   logic [PW1-1:0] gdiff;
   assign gdiff = (gx_ff > gy_ff) ? gx_ff - gy_ff : gy_ff - gx_ff;

   // divider step
   logic [PW1:0] tn, td;
   assign tn = {rn_ff, qn_ff[PW1-1]} - {1'b0, g_ff};
   assign td = {rd_ff, qd_ff[PW1-1]} - {1'b0, g_ff};

   logic [PW1-1:0] lim;
   assign lim = PW1'(1) << (W - 1);

   always_comb begin
      kind_in = kind_ff; nm_in = nm_ff; dm_in = dm_ff; neg_in = neg_ff;
      gx_in = gx_ff; gy_in = gy_ff; sh_in = sh_ff;
      qn_in = qn_ff; qd_in = qd_ff; rn_in = rn_ff; rd_in = rd_ff;
      cnt_in = cnt_ff; qk_in = 1'b0; done_in = 1'b0;
      on_in = on_ff; od_in = od_ff; oe_in = oe_ff; os_in = os_ff;
      csum = '0; cneg = 1'b0;
      if (cmd.load) begin
         kind_in = req_kind;
         on_in = '0; od_in = 31'd1; oe_in = 1'b0; os_in = rau_pkg::ST_OK;
         if (req_kind == rau_pkg::KIND_SPARE) begin
            qk_in = 1'b1;
         end else if (d1[W-1:0] == '0 || (uses_b && d3[W-1:0] == '0)) begin
            os_in = rau_pkg::ST_ZERO_DEN; qk_in = 1'b1;
         end else if (req_kind == rau_pkg::KIND_DIV && d2[W-1:0] == '0) begin
            os_in = rau_pkg::ST_DIV_ZERO; qk_in = 1'b1;
         end
      end else if (cmd.step) begin
         unique case (cmd.op)
            rau_pkg::OP_PRODUCT: begin
            end
            rau_pkg::OP_COMBINE: begin
               unique case (kind_ff)
                  rau_pkg::KIND_NORM, rau_pkg::KIND_NEG: begin
                     nm_in = {{(PW1-W){1'b0}}, an_m};
                     dm_in = {{(PW1-W){1'b0}}, ad_m};
                     neg_in = (an_s ^ (kind_ff == rau_pkg::KIND_NEG)) ^ ad_s;
                  end
                  rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_EQ: begin
                     if (s0_ff == sub_neg) begin
                        csum = ca + cb; cneg = s0_ff;
                     end else if (ca >= cb) begin
                        csum = ca - cb; cneg = s0_ff;
                     end else begin
                        csum = cb - ca; cneg = sub_neg;
                     end
                     nm_in = csum; dm_in = {1'b0, p2_ff};
                     neg_in = cneg ^ s2_ff;
                  end
                  default: begin
                     nm_in = {1'b0, p0_ff}; dm_in = {1'b0, p1_ff};
                     neg_in = s0_ff ^ s1_ff;
                  end
               endcase
               gx_in = nm_in; gy_in = dm_in; sh_in = '0;
               if (kind_ff == rau_pkg::KIND_EQ) begin
                  oe_in = (csum == '0); qk_in = 1'b1;
               end else if (nm_in == '0) begin
                  qk_in = 1'b1;
               end
            end
            rau_pkg::OP_GCD: begin
               if (gx_ff[0] == 1'b0 && gy_ff[0] == 1'b0) begin
                  gx_in = gx_ff >> 1; gy_in = gy_ff >> 1; sh_in = sh_ff + 1'b1;
               end else if (gx_ff[0] == 1'b0) begin
                  gx_in = gx_ff >> 1;
               end else if (gy_ff[0] == 1'b0) begin
                  gy_in = gy_ff >> 1;
               end else begin
                  gx_in = (gx_ff < gy_ff) ? gx_ff : gy_ff;
                  gy_in = gdiff;
               end
               qn_in = nm_ff; qd_in = dm_ff; rn_in = '0; rd_in = '0;
               cnt_in = CW'(PW1);
               if (gy_ff == '0) done_in = 1'b1;
            end
            rau_pkg::OP_DIVIDE: begin
               qn_in = {qn_ff[PW1-2:0], ~tn[PW1]};
               rn_in = tn[PW1] ? {rn_ff[PW1-2:0], qn_ff[PW1-1]} : tn[PW1-1:0];
               qd_in = {qd_ff[PW1-2:0], ~td[PW1]};
               rd_in = td[PW1] ? {rd_ff[PW1-2:0], qd_ff[PW1-1]} : td[PW1-1:0];
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  done_in = 1'b1;
                  if (qd_in > lim - 1'b1 || qn_in > (neg_ff ? lim : lim - 1'b1)) begin
                     os_in = rau_pkg::ST_OVERFLOW;
                  end else begin
                     on_in = neg_ff ? 32'(~qn_in + 1'b1) : 32'(qn_in);
                     od_in = 31'(qd_in);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (cmd.load) begin
         am_ff <= d0[W-1:0]; as_ff <= d0[W];
         adm_ff <= d1[W-1:0]; ads_ff <= d1[W];
         bm_ff <= d2[W-1:0]; bs_ff <= d2[W];
         bdm_ff <= d3[W-1:0]; bds_ff <= d3[W];
      end
      if (cmd.step && cmd.op == rau_pkg::OP_PRODUCT) begin
         unique case (kind_ff)
            rau_pkg::KIND_MUL: begin
               p0_ff <= an_m * bn_m; s0_ff <= an_s ^ bn_s;
               p1_ff <= ad_m * bd_m; s1_ff <= ad_s ^ bd_s;
            end
            rau_pkg::KIND_DIV: begin
               p0_ff <= an_m * bd_m; s0_ff <= an_s ^ bd_s;
               p1_ff <= ad_m * bn_m; s1_ff <= ad_s ^ bn_s;
            end
            default: begin
               p0_ff <= an_m * bd_m; s0_ff <= an_s ^ bd_s;
               p1_ff <= bn_m * ad_m; s1_ff <= bn_s ^ ad_s;
            end
         endcase
         p2_ff <= ad_m * bd_m; s2_ff <= ad_s ^ bd_s;
      end
      if (cmd.step && cmd.op == rau_pkg::OP_GCD && gy_ff == '0) begin
         g_ff <= gx_ff << sh_ff;
      end
      nm_ff <= nm_in; dm_ff <= dm_in; neg_ff <= neg_in;
      gx_ff <= gx_in; gy_ff <= gy_in; sh_ff <= sh_in;
      qn_ff <= qn_in; qd_ff <= qd_in; rn_ff <= rn_in; rd_ff <= rd_in;
      cnt_ff <= cnt_in; qk_ff <= qk_in; done_ff <= done_in;
      on_ff <= on_in; od_ff <= od_in; oe_ff <= oe_in; os_ff <= os_in;
   end

   assign sts.quick  = qk_ff;
   assign sts.done   = done_ff;
   assign res_num    = on_ff;
   assign res_den    = od_ff;
   assign res_eq     = oe_ff;
   assign res_status = os_ff;
endmodule

// ===== rtl/rau_control.sv =====
// Controller: sequences load, product, combine, GCD and divide phases.
module rau_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output rau_pkg::cmd_type cmd,
   input  rau_pkg::sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CHECK   = 6'b000010,
      S_PRODUCT = 6'b000100,
      S_COMBINE = 6'b001000,
      S_GCD     = 6'b010000,
      S_DIVIDE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      cmd.op   = rau_pkg::OP_PRODUCT;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.quick) begin
               valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.step = 1'b1; cmd.op = rau_pkg::OP_PRODUCT; state_in = S_PRODUCT;
            end
         end
         S_PRODUCT: begin
            cmd.step = 1'b1; cmd.op = rau_pkg::OP_COMBINE; state_in = S_COMBINE;
         end
         S_COMBINE: begin
            if (sts.quick) begin
               valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.step = 1'b1; cmd.op = rau_pkg::OP_GCD; state_in = S_GCD;
            end
         end
         S_GCD: begin
            cmd.step = 1'b1;
            if (sts.done) begin
               cmd.op = rau_pkg::OP_DIVIDE; state_in = S_DIVIDE;
            end else begin
               cmd.op = rau_pkg::OP_GCD;
            end
         end
         S_DIVIDE: begin
            if (sts.done) begin
               valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.step = 1'b1; cmd.op = rau_pkg::OP_DIVIDE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request without busy");
endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit.
// channel  | ports                                   | handshake
// request  | req_kind req_a_num req_a_den req_b_*     | start && !busy
// response | rsp_res_num rsp_res_den rsp_is_equal ... | rsp_valid, one cycle
// Zero-denominator and divide-by-zero errors and kind 7 answer from the check state,
// equality and zero results from the combine state; other kinds run the binary GCD
// loop and then the bit-serial dividers, and overflow is reported after the dividers.
// Reset is synchronous and clears the controller. The receiver cannot stall.
module rational_arithmetic_unit_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic        rsp_is_equal,
   output logic [1:0]  rsp_status
);
   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;

   rau_control u_ctrl (
      .clock, .reset, .start, .busy, .rsp_valid, .cmd, .sts
   );

   rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .req_kind, .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .cmd, .sts, .res_num(rsp_res_num), .res_den(rsp_res_den),
      .res_eq(rsp_is_equal), .res_status(rsp_status)
   );
endmodule
